// ===== rtl/tic_pkg.sv =====
// Shared types, constants and helper functions for the tryte integer codec.
// Used by tic_alu and tryte_integer_codec; depends on nothing.
package tic_pkg;

    localparam int MAX_DIGITS = 14;
    localparam int RADIX      = 27;
    localparam int DIGIT_MAX  = 13;
    localparam int WORD_W     = 64;
    localparam int WEIGHT_W   = 63;
    localparam int COUNT_W    = 4;
    localparam int DIG_IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int DIV_STEPS  = WORD_W / 4;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [7:0] CHAR_ZERO = 8'h39;  // '9'
    localparam logic [7:0] CHAR_BASE = 8'h40;  // '@'
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_Z    = 8'h5A;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NEG,
        ST_DIV,
        ST_ADJ,
        ST_EMIT,
        ST_MUL,
        ST_WGT,
        ST_DRES
    } state_t;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic              sub;
    } alu_req_t;

    typedef struct packed {
        logic       ok;
        logic       neg;
        logic [3:0] mag;
    } char_dig_t;

    typedef logic signed [4:0] digit_t;

    // one radix-16 step of a long division by 27: quotient nibble of a value below 432
    function automatic logic [3:0] div27_step(input logic [8:0] x);
        logic [3:0] q;
        q = '0;
        for (int k = 1; k < 16; k++) begin
            if (x >= 9'(RADIX * k)) begin
                q = q + 4'd1;
            end
        end
        return q;
    endfunction

    function automatic logic [7:0] digit_char(input digit_t d);
        logic [4:0] idx;
        idx = d[4] ? (5'(d) + 5'(RADIX)) : 5'(d);
        if (idx == 5'd0) begin
            return CHAR_ZERO;
        end
        return CHAR_BASE + {3'b000, idx};
    endfunction

    function automatic char_dig_t char_digit(input logic [7:0] c);
        char_dig_t  r;
        logic [4:0] v;
        r = '0;
        v = 5'(c - CHAR_BASE);
        if (c == CHAR_ZERO) begin
            r.ok = 1'b1;
        end else if (c >= CHAR_A && c <= CHAR_Z) begin
            r.ok = 1'b1;
            if (v > 5'(DIGIT_MAX)) begin
                r.neg = 1'b1;
                r.mag = 4'(5'(RADIX) - v);
            end else begin
                r.mag = v[3:0];
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/tic_alu.sv =====
// Shared 64-bit add/subtract unit of the tryte integer codec.
// Depends on tic_pkg for the request struct.
module tic_alu (
    input  tic_pkg::alu_req_t            req,
    output logic [tic_pkg::WORD_W-1:0]   sum
);

    assign sum = req.sub ? (req.a - req.b) : (req.a + req.b);

endmodule

// ===== rtl/tryte_integer_codec.sv =====
// Top level of the balanced base-27 tryte codec: sequencer, registers and output stage.
// Depends on tic_pkg and tic_alu.
//
// Use: one input channel (s_*) and one result channel (m_*), both valid/ready.
// s_tuser selects the request: 0 encodes s_tdata[63:0], 1 decodes the character in
// s_tdata[71:64]; s_tlast marks the last character of a decoded string.
// Encode: a negative value is first negated; the magnitude is then divided by 27 in
// a radix-16 long division, and each digit is balanced before the next division.
// All digits are formed before the first result leaves, then one result per
// digit (at most 14) is sent, one per cycle when the receiver is ready; m_tlast
// marks the final digit. s_tready stays low until the last digit has been sent.
// Decode: each character is accepted, then digit times weight is added to or
// subtracted from the accumulator by shift-add steps, then the weight is multiplied
// by 27; the fourteenth skips the weight and characters past the limit are only
// accepted. After the last character the single result, which has m_tlast high, is loaded.
// A new request is taken only in the idle state, also while a result waits in the
// output register; a stalled result holds and the sequencer waits to load the next.
// Reset (aresetn low, synchronous) returns to idle, drops any pending result and
// clears the decode accumulator, position and flags.
module tryte_integer_codec (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [63:0] value_in, [71:64] tryte_char_in
    input  logic        s_tuser,   // [0] mode
    input  logic        s_tlast,   // last_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [7:0] tryte_char_out, [11:8] digit_index,
                                   // [15:12] digit_count, [79:16] value_out
    output logic [1:0]  m_tuser,   // [0] bad_char, [1] overflow
    output logic        m_tlast    // last_digit
);

    localparam int W  = tic_pkg::WORD_W;
    localparam int CW = tic_pkg::COUNT_W;

    tic_pkg::state_t   state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;

    // encode path
    logic [W-1:0]      mag_reg, mag_next;
    logic              neg_reg, neg_next;
    logic [4:0]        rem_reg, rem_next;
    logic [CW-1:0]     ncnt_reg, ncnt_next;
    logic              trunc_reg, trunc_next;
    logic [CW-1:0]     kidx_reg, kidx_next;
    tic_pkg::digit_t   digit_reg [tic_pkg::MAX_DIGITS];
    logic              dig_we;
    logic              dig_re;
    tic_pkg::digit_t   dig_wdata;

    // decode path
    logic [W-1:0]                   acc_reg, acc_next;
    logic [CW-1:0]                  dpos_reg, dpos_next;
    logic [tic_pkg::WEIGHT_W-1:0]   weight_reg, weight_next;
    logic                           bad_reg, bad_next;
    logic                           ovf_reg, ovf_next;
    logic [W-1:0]                   tmp_reg, tmp_next;
    logic [3:0]                     dmag_reg, dmag_next;
    logic                           dneg_reg, dneg_next;
    logic                           dlast_reg, dlast_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        out_char_reg, out_char_next;
    logic [CW-1:0]     out_idx_reg, out_idx_next;
    logic [CW-1:0]     out_cnt_reg, out_cnt_next;
    logic              out_last_reg, out_last_next;
    logic [W-1:0]      out_value_reg, out_value_next;
    logic              out_bad_reg, out_bad_next;
    logic              out_ovf_reg, out_ovf_next;

    tic_pkg::alu_req_t alu_req;
    logic [W-1:0]      alu_sum;

    logic              in_accept;
    logic              slot_free;
    logic [8:0]        div_x;
    logic [3:0]        div_q;
    logic [8:0]        div_r;
    logic              adj_hi;
    tic_pkg::digit_t   adj_d;
    tic_pkg::char_dig_t cdig;
    logic [CW-1:0]     ecount;
    logic [CW-1:0]     dpos_inc;
    logic [W-1:0]      weight_ext;

    tic_alu u_alu (
        .req (alu_req),
        .sum (alu_sum)
    );

    assign s_tready  = (state_reg == tic_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign slot_free = !m_valid_reg || m_tready;

    assign div_x   = {rem_reg, mag_reg[W-1 -: 4]};
    assign div_q   = tic_pkg::div27_step(div_x);
    assign div_r   = div_x - 9'({5'd0, div_q} * 9'(tic_pkg::RADIX));
    assign adj_hi  = rem_reg > 5'(tic_pkg::DIGIT_MAX);
    assign adj_d   = adj_hi ? tic_pkg::digit_t'(rem_reg - 5'(tic_pkg::RADIX))
                            : tic_pkg::digit_t'(rem_reg);
    assign cdig    = tic_pkg::char_digit(s_tdata[71:64]);
    assign ecount  = trunc_reg ? CW'(tic_pkg::MAX_DIGITS) : ncnt_reg;
    assign dpos_inc   = dpos_reg + 1'b1;
    assign weight_ext = {1'b0, weight_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tic_pkg::ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            acc_reg     <= '0;
            dpos_reg    <= '0;
            weight_reg  <= tic_pkg::WEIGHT_W'(1);
            bad_reg     <= 1'b0;
            ovf_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            acc_reg     <= acc_next;
            dpos_reg    <= dpos_next;
            weight_reg  <= weight_next;
            bad_reg     <= bad_next;
            ovf_reg     <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        rem_reg       <= rem_next;
        ncnt_reg      <= ncnt_next;
        trunc_reg     <= trunc_next;
        kidx_reg      <= kidx_next;
        tmp_reg       <= tmp_next;
        dmag_reg      <= dmag_next;
        dneg_reg      <= dneg_next;
        dlast_reg     <= dlast_next;
        if (dig_re) begin
            out_char_reg <= tic_pkg::digit_char(
                                digit_reg[kidx_reg[tic_pkg::DIG_IDX_W-1:0]]);
        end else begin
            out_char_reg <= out_char_next;
        end
        out_idx_reg   <= out_idx_next;
        out_cnt_reg   <= out_cnt_next;
        out_last_reg  <= out_last_next;
        out_value_reg <= out_value_next;
        out_bad_reg   <= out_bad_next;
        out_ovf_reg   <= out_ovf_next;
        if (dig_we) begin
            digit_reg[ncnt_reg[tic_pkg::DIG_IDX_W-1:0]] <= dig_wdata;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        ncnt_next      = ncnt_reg;
        trunc_next     = trunc_reg;
        kidx_next      = kidx_reg;
        tmp_next       = tmp_reg;
        dmag_next      = dmag_reg;
        dneg_next      = dneg_reg;
        dlast_next     = dlast_reg;
        acc_next       = acc_reg;
        dpos_next      = dpos_reg;
        weight_next    = weight_reg;
        bad_next       = bad_reg;
        ovf_next       = ovf_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_idx_next   = out_idx_reg;
        out_cnt_next   = out_cnt_reg;
        out_last_next  = out_last_reg;
        out_value_next = out_value_reg;
        out_bad_next   = out_bad_reg;
        out_ovf_next   = out_ovf_reg;
        dig_we         = 1'b0;
        dig_re         = 1'b0;
        dig_wdata      = neg_reg ? -adj_d : adj_d;
        alu_req.a      = mag_reg;
        alu_req.b      = W'(1);
        alu_req.sub    = 1'b0;

        unique case (state_reg)
            tic_pkg::ST_IDLE: begin
                if (in_accept) begin
                    cnt_next = '0;
                    if (s_tuser == tic_pkg::MODE_ENCODE) begin
                        mag_next   = s_tdata[W-1:0];
                        neg_next   = s_tdata[W-1];
                        rem_next   = '0;
                        ncnt_next  = '0;
                        trunc_next = 1'b0;
                        state_next = s_tdata[W-1] ? tic_pkg::ST_NEG : tic_pkg::ST_DIV;
                    end else begin
                        dlast_next = s_tlast;
                        if (!cdig.ok) begin
                            bad_next = 1'b1;
                        end
                        if (dpos_reg < CW'(tic_pkg::MAX_DIGITS)) begin
                            dmag_next  = cdig.mag;
                            dneg_next  = cdig.neg;
                            state_next = tic_pkg::ST_MUL;
                        end else begin
                            ovf_next   = 1'b1;
                            state_next = s_tlast ? tic_pkg::ST_DRES : tic_pkg::ST_IDLE;
                        end
                    end
                end
            end

            tic_pkg::ST_NEG: begin
                alu_req.a  = ~mag_reg;
                mag_next   = alu_sum;
                state_next = tic_pkg::ST_DIV;
            end

            tic_pkg::ST_DIV: begin
                mag_next = {mag_reg[W-5:0], div_q};
                rem_next = div_r[4:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(tic_pkg::DIV_STEPS - 1)) begin
                    state_next = tic_pkg::ST_ADJ;
                end
            end

            tic_pkg::ST_ADJ: begin
                // balance the digit: a remainder above 13 carries one into the quotient
                mag_next = adj_hi ? alu_sum : mag_reg;
                if (ncnt_reg < CW'(tic_pkg::MAX_DIGITS)) begin
                    dig_we = 1'b1;
                end else begin
                    trunc_next = 1'b1;
                end
                ncnt_next = ncnt_reg + 1'b1;
                rem_next  = '0;
                cnt_next  = '0;
                kidx_next = '0;
                if ((adj_hi ? alu_sum : mag_reg) == '0) begin
                    state_next = tic_pkg::ST_EMIT;
                end else begin
                    state_next = tic_pkg::ST_DIV;
                end
            end

            tic_pkg::ST_EMIT: begin
                if (slot_free) begin
                    m_valid_next   = 1'b1;
                    dig_re         = 1'b1;
                    out_idx_next   = kidx_reg;
                    out_cnt_next   = ecount;
                    out_last_next  = (kidx_reg == ecount - 1'b1);
                    out_value_next = '0;
                    out_bad_next   = 1'b0;
                    out_ovf_next   = trunc_reg;
                    kidx_next      = kidx_reg + 1'b1;
                    if (kidx_reg == ecount - 1'b1) begin
                        state_next = tic_pkg::ST_IDLE;
                    end
                end
            end

            tic_pkg::ST_MUL: begin
                alu_req.a   = acc_reg;
                alu_req.b   = weight_ext << cnt_reg[1:0];
                alu_req.sub = dneg_reg;
                if (dmag_reg[cnt_reg[1:0]]) begin
                    acc_next = alu_sum;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(3)) begin
                    dpos_next = dpos_inc;
                    cnt_next  = '0;
                    if (dpos_inc < CW'(tic_pkg::MAX_DIGITS)) begin
                        state_next = tic_pkg::ST_WGT;
                    end else begin
                        state_next = dlast_reg ? tic_pkg::ST_DRES : tic_pkg::ST_IDLE;
                    end
                end
            end

            tic_pkg::ST_WGT: begin
                // weight * 27 as w + 2w + 8w + 16w
                alu_req.a = tmp_reg;
                alu_req.b = weight_ext << 4;
                if (cnt_reg == CW'(0)) begin
                    alu_req.a = weight_ext;
                    alu_req.b = weight_ext << 1;
                end else if (cnt_reg == CW'(1)) begin
                    alu_req.b = weight_ext << 3;
                end
                tmp_next = alu_sum;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(2)) begin
                    weight_next = alu_sum[tic_pkg::WEIGHT_W-1:0];
                    state_next  = dlast_reg ? tic_pkg::ST_DRES : tic_pkg::ST_IDLE;
                end
            end

            tic_pkg::ST_DRES: begin
                if (slot_free) begin
                    m_valid_next   = 1'b1;
                    out_char_next  = '0;
                    out_idx_next   = '0;
                    out_cnt_next   = dpos_reg;
                    out_last_next  = 1'b1;
                    out_value_next = acc_reg;
                    out_bad_next   = bad_reg;
                    out_ovf_next   = ovf_reg;
                    acc_next       = '0;
                    dpos_next      = '0;
                    weight_next    = tic_pkg::WEIGHT_W'(1);
                    bad_next       = 1'b0;
                    ovf_next       = 1'b0;
                    state_next     = tic_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = tic_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_value_reg, out_cnt_reg, out_idx_reg, out_char_reg};
    assign m_tuser  = {out_ovf_reg, out_bad_reg};
    assign m_tlast  = out_last_reg;

    // decode position never runs past the digit limit
    a_dpos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        dpos_reg <= CW'(tic_pkg::MAX_DIGITS))
        else $error("decode position past limit");

    // long-division remainder stays below the radix
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == tic_pkg::ST_DIV |-> rem_reg < 5'(tic_pkg::RADIX))
        else $error("division remainder out of range");

    // a nonzero digit index always lies inside the digit count
    a_idx_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_idx_reg != '0 |-> out_idx_reg < out_cnt_reg)
        else $error("digit index beyond digit count");

    // a decode result clears the decode state once it is loaded
    a_dres_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == tic_pkg::ST_DRES && slot_free |=>
            acc_reg == '0 && dpos_reg == '0 && !bad_reg && !ovf_reg)
        else $error("decode state not cleared after result");

endmodule
